@@ hdl/mqms_pkg.sv @@
// Package for the multi-queue message scheduler: field structs, opcodes,
// status codes and sizing constants. No dependencies.
package mqms_pkg;

  localparam int unsigned NumQueues  = 8;
  localparam int unsigned QueueDepth = 2048;
  localparam int unsigned MsgWidth   = 64;
  localparam int unsigned QidW       = $clog2(NumQueues);
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned MemAw      = QidW + PtrW;
  localparam int unsigned RcntW      = $clog2(NumQueues + 1);
  localparam logic [15:0] BaseReset  = 16'd1024;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_TAKE    = 3'd2,
    OP_REQUEUE = 3'd3,
    OP_OVL     = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOREADY = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  queue_id;
    logic [63:0] payload_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  queue_out;
    logic [63:0] payload_out;
    logic [11:0] length;
    logic [11:0] overload_value;
  } rsp_t;

endpackage

@@ hdl/multi_queue_message_scheduler.sv @@
// Multi-queue message scheduler top level: per-queue FIFOs in one shared
// message memory, plus a ready ring of queue numbers. Uses mqms_pkg.
//
//  channel | signals                       | dir
//  req     | req_valid_i/req_ready_o/req_i | in
//  rsp     | rsp_valid_o/rsp_ready_i/rsp_o | out
//  cfg     | cfg_we_i/cfg_data_i           | in
//
// For push, take, requeue, overload read and empty pop, the accept edge
// updates control state and issues the memory write or read, and the second
// phase loads the response register. A pop that returns a message instead
// copies the read data into the response there, does k threshold doublings
// (up to 11) and closes the walk. Input is stalled while a request is in
// flight; the second phase waits while the response register is full.
// Reset sets all control state at once; no clearing pass is needed.
module multi_queue_message_scheduler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  mqms_pkg::req_t       req_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output mqms_pkg::rsp_t       rsp_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_data_i
);
  import mqms_pkg::*;

  logic [MsgWidth-1:0] mem_q [NumQueues*QueueDepth];
  logic [MsgWidth-1:0] rdata_q;

  logic [PtrW-1:0]  rptr_q [NumQueues];
  logic [PtrW-1:0]  wptr_q [NumQueues];
  logic [CntW-1:0]  fill_q [NumQueues];
  logic [15:0]      thr_q  [NumQueues];
  logic [11:0]      ovl_q  [NumQueues];
  logic [NumQueues-1:0] sched_q;
  logic [QidW-1:0]  ring_q [NumQueues];
  logic [QidW-1:0]  rhead_q, rtail_q;
  logic [RcntW-1:0] rcnt_q;
  logic [15:0]      base_q;

  // second-phase request info
  logic             busy_q;
  logic [QidW-1:0]  qid_q;
  logic             popok_q;
  logic [1:0]       st_q;
  logic [QidW-1:0]  qout_q;
  logic [11:0]      ovlv_q;

  // overload threshold walk after a pop
  logic             walk_q;
  logic [CntW-1:0]  wlen_q;
  logic [15:0]      wth_q;

  logic             rsp_valid_q;
  rsp_t             rsp_q;

  logic             accept;
  logic [QidW-1:0]  q;
  logic [2:0]       op;
  logic [15:0]      base_eff;
  logic [16:0]      th_dbl;

  assign req_ready_o = !busy_q && !walk_q;
  assign accept      = req_valid_i && req_ready_o;
  assign q           = req_i.queue_id[QidW-1:0];
  assign op          = req_i.opcode;
  assign base_eff    = (base_q == 16'd0) ? 16'd1 : base_q;
  assign th_dbl      = {wth_q, 1'b0};
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // message memory: one write and one read port, write on push, read on every accept
  always_ff @(posedge clk_i) begin
    if (accept && op == OP_PUSH && fill_q[q] < CntW'(QueueDepth) &&
        (sched_q[q] || rcnt_q < RcntW'(NumQueues))) begin
      mem_q[{q, wptr_q[q]}] <= req_i.payload_in[MsgWidth-1:0];
    end
    // read data is held until the second phase takes it
    if (accept) begin
      rdata_q <= mem_q[{q, rptr_q[q]}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumQueues; i++) begin
        rptr_q[i] <= '0;
        wptr_q[i] <= '0;
        fill_q[i] <= '0;
        thr_q[i]  <= BaseReset;
        ovl_q[i]  <= '0;
        ring_q[i] <= '0;
      end
      sched_q     <= '1;
      rhead_q     <= '0;
      rtail_q     <= '0;
      rcnt_q      <= '0;
      base_q      <= BaseReset;
      busy_q      <= 1'b0;
      qid_q       <= '0;
      popok_q     <= 1'b0;
      st_q        <= ST_OK;
      qout_q      <= '0;
      ovlv_q      <= '0;
      walk_q      <= 1'b0;
      wlen_q      <= '0;
      wth_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end

      if (accept) begin
        busy_q  <= 1'b1;
        qid_q   <= q;
        popok_q <= 1'b0;
        st_q    <= ST_OK;
        qout_q  <= q;
        ovlv_q  <= '0;
        unique case (op)
          OP_PUSH: begin
            if (fill_q[q] >= CntW'(QueueDepth)) begin
              st_q <= ST_FULL;
            end else if (!sched_q[q] && rcnt_q >= RcntW'(NumQueues)) begin
              st_q <= ST_FULL;
            end else begin
              if (!sched_q[q]) begin
                sched_q[q]      <= 1'b1;
                ring_q[rtail_q] <= q;
                rtail_q         <= rtail_q + 1'b1;
                rcnt_q          <= rcnt_q + 1'b1;
              end
              wptr_q[q] <= wptr_q[q] + 1'b1;
              fill_q[q] <= fill_q[q] + 1'b1;
            end
          end
          OP_POP: begin
            if (fill_q[q] == '0) begin
              thr_q[q]   <= base_eff;
              sched_q[q] <= 1'b0;
              st_q       <= ST_EMPTY;
            end else begin
              popok_q   <= 1'b1;
              rptr_q[q] <= rptr_q[q] + 1'b1;
              fill_q[q] <= fill_q[q] - 1'b1;
              wlen_q    <= fill_q[q] - 1'b1;
              wth_q     <= (thr_q[q] == 16'd0) ? 16'd1 : thr_q[q];
            end
          end
          OP_TAKE: begin
            if (rcnt_q == '0) begin
              st_q <= ST_NOREADY;
            end else begin
              qout_q  <= ring_q[rhead_q];
              rhead_q <= rhead_q + 1'b1;
              rcnt_q  <= rcnt_q - 1'b1;
            end
          end
          OP_REQUEUE: begin
            if (rcnt_q >= RcntW'(NumQueues)) begin
              st_q <= ST_FULL;
            end else begin
              ring_q[rtail_q] <= q;
              rtail_q         <= rtail_q + 1'b1;
              rcnt_q          <= rcnt_q + 1'b1;
            end
          end
          OP_OVL: begin
            ovlv_q   <= ovl_q[q];
            ovl_q[q] <= '0;
          end
          default: ;
        endcase
      end else if (busy_q && !walk_q && (!rsp_valid_q || rsp_ready_i)) begin
        if (popok_q) begin
          rsp_q.payload_out <= 64'(rdata_q);
          walk_q            <= 1'b1;
          popok_q           <= 1'b0;
        end else begin
          busy_q               <= 1'b0;
          rsp_valid_q          <= 1'b1;
          rsp_q.status         <= st_q;
          rsp_q.queue_out      <= 3'(qout_q);
          rsp_q.payload_out    <= '0;
          rsp_q.length         <= 12'(fill_q[qout_q]);
          rsp_q.overload_value <= ovlv_q;
        end
      end else if (walk_q) begin
        // one threshold doubling per cycle
        if (16'(wlen_q) > wth_q) begin
          ovl_q[qid_q] <= 12'(wlen_q);
          wth_q        <= th_dbl[16] ? 16'hFFFF : th_dbl[15:0];
        end else begin
          thr_q[qid_q]         <= wth_q;
          walk_q               <= 1'b0;
          busy_q               <= 1'b0;
          rsp_valid_q          <= 1'b1;
          rsp_q.status         <= ST_OK;
          rsp_q.queue_out      <= 3'(qid_q);
          rsp_q.length         <= 12'(wlen_q);
          rsp_q.overload_value <= '0;
        end
      end
    end
  end

endmodule
